// ----- src/deq_pkg.sv -----
// Shared constants, command codes and control types for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_PEEK       = 3'd5
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_FETCH,
    S_DELIVER
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic update;
    logic fetch;
    logic deliver;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/deq_ctrl.sv -----
// Sequencing state machine for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output deq_pkg::dp_cmd_t       cmd,
  input  wire deq_pkg::dp_stat_t stat
);
  import deq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DELIVER;
      end
      S_DELIVER: begin
        if (!stat.out_busy) begin
          cmd.deliver = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/deq_dp.sv -----
// Datapath of the double-ended queue: ring store, indices, count and result register.
`timescale 1ns / 1ps
`default_nettype none
module deq_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire deq_pkg::dp_cmd_t       cmd,
  output deq_pkg::dp_stat_t           stat,
  input  wire logic [deq_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [deq_pkg::WORD_W-1:0] in_value,
  input  wire logic                   m_tready,
  output logic                        m_tvalid,
  output logic [deq_pkg::WORD_W-1:0]  out_front,
  output logic [deq_pkg::WORD_W-1:0]  out_back,
  output logic [deq_pkg::COUNT_W-1:0] out_count,
  output logic                        out_empty,
  output logic                        out_full,
  output logic [deq_pkg::STATUS_W-1:0] out_status
);
  import deq_pkg::*;

  logic [WORD_W-1:0]   slots [DEPTH];
  logic [CMD_W-1:0]    op;
  logic [WORD_W-1:0]   word;
  logic [IDX_W-1:0]    front_index, front_index_next;
  logic [IDX_W-1:0]    back_index, back_index_next;
  logic [CNT_W-1:0]    element_count, element_count_next;
  logic [STATUS_W-1:0] status, status_next;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [WORD_W-1:0]   rd_front, rd_back;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  // hold the accepted command and word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_cmd;
      word <= in_value;
    end
  end

  always_comb begin
    front_index_next   = front_index;
    back_index_next    = back_index;
    element_count_next = element_count;
    status_next        = ST_DONE;
    wr_en              = 1'b0;
    wr_idx             = front_index;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (element_count >= CNT_W'(DEPTH)) begin
          status_next = ST_PUSH_FULL;
        end else if (element_count == '0) begin
          back_index_next    = front_index;
          wr_en              = 1'b1;
          wr_idx             = front_index;
          element_count_next = CNT_W'(1);
        end else if (op == CMD_PUSH_FRONT) begin
          front_index_next   = ring_prev(front_index);
          wr_en              = 1'b1;
          wr_idx             = front_index_next;
          element_count_next = element_count + 1'b1;
        end else begin
          back_index_next    = ring_next(back_index);
          wr_en              = 1'b1;
          wr_idx             = back_index_next;
          element_count_next = element_count + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (element_count == '0) begin
          status_next = ST_POP_EMPTY;
        end else begin
          element_count_next = element_count - 1'b1;
          if (element_count_next == '0) begin
            back_index_next = front_index;
          end else if (op == CMD_POP_FRONT) begin
            front_index_next = ring_next(front_index);
          end else begin
            back_index_next = ring_prev(back_index);
          end
        end
      end
      CMD_CLEAR: begin
        element_count_next = '0;
        front_index_next   = '0;
        back_index_next    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index   <= '0;
      back_index    <= '0;
      element_count <= '0;
    end else if (cmd.update) begin
      front_index   <= front_index_next;
      back_index    <= back_index_next;
      element_count <= element_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      status <= status_next;
    end
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      slots[wr_idx] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_front <= slots[front_index];
      rd_back  <= slots[back_index];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.deliver) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_front  <= (element_count == '0) ? '0 : rd_front;
      out_back   <= (element_count == '0) ? '0 : rd_back;
      out_count  <= COUNT_W'(element_count);
      out_empty  <= (element_count == '0);
      out_full   <= (element_count == CNT_W'(DEPTH));
      out_status <= status;
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;

  // distance from front to back around the ring
  logic [CNT_W:0] span;
  assign span = (back_index >= front_index)
              ? (CNT_W+1)'(back_index) - (CNT_W+1)'(front_index)
              : (CNT_W+1)'(back_index) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(front_index);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  a_empty_aligned: assert property (@(posedge clk) disable iff (rst)
    (element_count == '0) |-> (back_index == front_index))
    else $error("indices apart while empty");

  a_ring_span: assert property (@(posedge clk) disable iff (rst)
    (element_count != '0) |-> (span + 1'b1 == (CNT_W+1)'(element_count)))
    else $error("index span disagrees with element count");

endmodule
`default_nettype wire

// ----- src/double_ended_queue.sv -----
// Top level of the double-ended queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Bounded double-ended queue of DEPTH signed 32-bit words held in a ring store.
// Each input word carries a command in s_tuser (push front, push back, pop
// front, pop back, clear, peek; codes 6 and 7 act as peek) and, for pushes,
// the word to store in s_tdata. Every command returns exactly one result
// word: front and back elements after the command (0 when empty), count,
// empty and full flags, and a status (0 done, 1 push rejected as full, 2 pop
// rejected as empty). A command passes from acceptance to result through these
// steps: accept, update indices and write the slot, read both ends from the ring
// store through its registered read ports, and load the result register.
// The next command is accepted in the cycle after a result is loaded, so a new
// command is never accepted while another is in progress. The result register
// lets a new command start while an earlier result waits to be taken.
// Slot contents are not cleared by reset; only written slots reach the output.
module double_ended_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic [7:0]  s_tuser,   // [2:0] cmd, [7:3] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata    // [31:0] front_value, [63:32] back_value,
                                      // [68:64] count, [69] is_empty,
                                      // [70] is_full, [72:71] status, [79:73] zero
);
  import deq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [WORD_W-1:0]   front_value;
  logic [WORD_W-1:0]   back_value;
  logic [COUNT_W-1:0]  count;
  logic                is_empty;
  logic                is_full;
  logic [STATUS_W-1:0] status;

  // sequence each command through update, fetch and deliver
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // ring store, indices, count and result register
  deq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (s_tuser[CMD_W-1:0]),
    .in_value   (s_tdata),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .out_front  (front_value),
    .out_back   (back_value),
    .out_count  (count),
    .out_empty  (is_empty),
    .out_full   (is_full),
    .out_status (status)
  );

  // pack the result word, lowest field first, padded to whole bytes
  assign m_tdata = {7'b0, status, is_full, is_empty, count, back_value, front_value};

endmodule
`default_nettype wire
